// ----- hdl/pes_pkg.sv -----
package pes_pkg;

   // Capacity of one run and geometry of the element and prefix stores.
   localparam int MAX_LEN     = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = 6;
   localparam int COUNT_W     = 7;
   localparam int DATA_W      = 32;

   // Result transfer layout: index in the low bits, product above, zero padding.
   localparam int INDEX_W     = 6;
   localparam int RSP_DATA_W  = 40;

   // Access control for the element and prefix stores.
   typedef struct packed {
      logic                we_elem;
      logic                we_pref;
      logic [ADDR_W-1:0]   waddr;
      logic                re;
      logic [ADDR_W-1:0]   raddr;
   } mem_ctrl_type;

endpackage

// ----- hdl/pes_mul.sv -----
module pes_mul (
   input  logic                      clock,
   input  logic [pes_pkg::DATA_W-1:0] op_a,
   input  logic [pes_pkg::DATA_W-1:0] op_b,
   output logic [pes_pkg::DATA_W-1:0] product
);
   import pes_pkg::*;

   logic [DATA_W-1:0]   full_prod;
   logic [DATA_W-1:0]   product_ff;

   // Only the low word is kept, so signed and unsigned operands give the same bits.
   assign full_prod = op_a * op_b;

   // Registered result of the shared multiplier.
   always_ff @(posedge clock) begin
      product_ff <= full_prod;
   end

   assign product = product_ff;

endmodule

// ----- hdl/pes_mem.sv -----
module pes_mem (
   input  logic                       clock,
   input  pes_pkg::mem_ctrl_type      ctrl,
   input  logic [pes_pkg::DATA_W-1:0] wdata_elem,
   input  logic [pes_pkg::DATA_W-1:0] wdata_pref,
   output logic [pes_pkg::DATA_W-1:0] rdata_elem,
   output logic [pes_pkg::DATA_W-1:0] rdata_pref
);
   import pes_pkg::*;

   logic [DATA_W-1:0] elem_mem [STORE_DEPTH];
   logic [DATA_W-1:0] pref_mem [STORE_DEPTH];
   logic [DATA_W-1:0] rd_elem_ff;
   logic [DATA_W-1:0] rd_pref_ff;

   // Write port of both stores, sharing one address.
   always_ff @(posedge clock) begin
      if (ctrl.we_elem) begin
         elem_mem[ctrl.waddr] <= wdata_elem;
      end
      if (ctrl.we_pref) begin
         pref_mem[ctrl.waddr] <= wdata_pref;
      end
   end

   // Registered read port of both stores.
   always_ff @(posedge clock) begin
      if (ctrl.re) begin
         rd_elem_ff <= elem_mem[ctrl.raddr];
         rd_pref_ff <= pref_mem[ctrl.raddr];
      end
   end

   assign rdata_elem = rd_elem_ff;
   assign rdata_pref = rd_pref_ff;

endmodule

// ----- hdl/product_except_self.sv -----
// Product of a vector's elements except self. Elements arrive one per req transfer,
// with req_tlast on the final one; up to MAX_LEN elements are kept and later ones are
// dropped, which sets the truncated flag (rsp_tuser) on every result of that run.
// Once the final element is in, the block walks back through the stored elements and
// then returns one result per element in ascending index order, rsp_tlast marking the
// final index; all products wrap to 32 bits and a one-element vector gives 1. A stored
// non-final element also needs a write-back step (the running prefix goes through the
// one shared multiplier and is written back); a dropped or final element does not.
// In the backward pass each stored element needs a store read and two multiplications
// on the shared multiplier. Each result is then read from the store and held until
// rsp_tready takes it. req_tready is low from the final element until the last result
// transfer and during each prefix write-back. The stores need no clearing after reset.
module product_except_self (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: value[31:0]
   input  logic [pes_pkg::DATA_W-1:0]     req_tdata,
   input  logic                           req_tlast,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // rsp_tdata: index[5:0], product[37:6], zero padding[39:38]
   output logic [pes_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: truncated[0]
   output logic [0:0]                     rsp_tuser,
   output logic                           rsp_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready
);
   import pes_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_LOAD_WB = 8'b0000_0010,
      ST_B_RD    = 8'b0000_0100,
      ST_B_M1    = 8'b0000_1000,
      ST_B_M2    = 8'b0001_0000,
      ST_E_RD    = 8'b0010_0000,
      ST_E_LD    = 8'b0100_0000,
      ST_E_HOLD  = 8'b1000_0000
   } state_type;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_LEN);
   localparam logic [DATA_W-1:0]  ONE_WORD  = DATA_W'(1);

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0]   prefix_ff, prefix_in;
   logic [DATA_W-1:0]   suffix_ff, suffix_in;
   logic                dropped_ff, dropped_in;
   logic                first_ff, first_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]   last_idx_ff, last_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [DATA_W-1:0]   rsp_product_ff;
   logic                rsp_end_ff;
   logic                rsp_trunc_ff;
   logic                load_rsp;

   logic [DATA_W-1:0]   mul_a, mul_b, mul_p;
   mem_ctrl_type        mem_ctrl;
   logic [DATA_W-1:0]   wdata_pref;
   logic [DATA_W-1:0]   rd_elem, rd_pref;
   logic [COUNT_W-1:0]  count_m1;
   logic                req_xfer, rsp_xfer, stored;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;
   assign stored     = (count_ff < MAX_COUNT);
   assign count_m1   = count_ff - COUNT_W'(1);

   // Shared multiplier and the two stores.
   pes_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   pes_mem u_mem (
      .clock      (clock),
      .ctrl       (mem_ctrl),
      .wdata_elem (req_tdata),
      .wdata_pref (wdata_pref),
      .rdata_elem (rd_elem),
      .rdata_pref (rd_pref)
   );

   // Sequencer: load, backward suffix pass, ascending emission.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      prefix_in    = prefix_ff;
      suffix_in    = suffix_ff;
      dropped_in   = dropped_ff;
      first_in     = first_ff;
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      load_rsp     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      wdata_pref   = mul_p;
      mem_ctrl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            wdata_pref = prefix_ff;
            if (req_xfer) begin
               if (stored) begin
                  mem_ctrl.we_elem = 1'b1;
                  mem_ctrl.we_pref = 1'b1;
                  mem_ctrl.waddr   = count_ff[ADDR_W-1:0];
                  mul_a            = prefix_ff;
                  mul_b            = req_tdata;
                  count_in         = count_ff + COUNT_W'(1);
                  last_idx_in      = count_ff[ADDR_W-1:0];
               end else begin
                  dropped_in  = 1'b1;
                  last_idx_in = count_m1[ADDR_W-1:0];
               end
               if (req_tlast) begin
                  idx_in   = stored ? count_ff[ADDR_W-1:0] : count_m1[ADDR_W-1:0];
                  first_in = 1'b1;
                  state_in = ST_B_RD;
               end else if (stored) begin
                  state_in = ST_LOAD_WB;
               end
            end
         end
         ST_LOAD_WB: begin
            prefix_in = mul_p;
            state_in  = ST_IDLE;
         end
         ST_B_RD: begin
            // The suffix product issued in ST_B_M2 for the previous element lands here.
            mem_ctrl.re    = 1'b1;
            mem_ctrl.raddr = idx_ff;
            if (!first_ff) begin
               suffix_in = mul_p;
            end
            first_in = 1'b0;
            state_in = ST_B_M1;
         end
         ST_B_M1: begin
            mul_a    = rd_pref;
            mul_b    = suffix_ff;
            state_in = ST_B_M2;
         end
         ST_B_M2: begin
            // Result overwrites the prefix entry; then advance the suffix.
            mem_ctrl.we_pref = 1'b1;
            mem_ctrl.waddr   = idx_ff;
            mul_a            = rd_elem;
            mul_b            = suffix_ff;
            if (idx_ff == '0) begin
               state_in = ST_E_RD;
            end else begin
               idx_in   = idx_ff - ADDR_W'(1);
               state_in = ST_B_RD;
            end
         end
         ST_E_RD: begin
            mem_ctrl.re    = 1'b1;
            mem_ctrl.raddr = idx_ff;
            state_in       = ST_E_LD;
         end
         ST_E_LD: begin
            load_rsp     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_E_HOLD;
         end
         ST_E_HOLD: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               if (idx_ff == last_idx_ff) begin
                  count_in   = '0;
                  prefix_in  = ONE_WORD;
                  suffix_in  = ONE_WORD;
                  dropped_in = 1'b0;
                  idx_in     = '0;
                  state_in   = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_E_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         prefix_ff    <= ONE_WORD;
         suffix_ff    <= ONE_WORD;
         dropped_ff   <= 1'b0;
         first_ff     <= 1'b0;
         idx_ff       <= '0;
         last_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         prefix_ff    <= prefix_in;
         suffix_ff    <= suffix_in;
         dropped_ff   <= dropped_in;
         first_ff     <= first_in;
         idx_ff       <= idx_in;
         last_idx_ff  <= last_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_index_ff   <= idx_ff;
         rsp_product_ff <= rd_pref;
         rsp_end_ff     <= (idx_ff == last_idx_ff);
         rsp_trunc_ff   <= dropped_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DATA_W - INDEX_W){1'b0}}, rsp_product_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_trunc_ff;
   assign rsp_tlast  = rsp_end_ff;

`ifndef NO_ASSERTIONS
   // The block never takes a new element while a result is on offer.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("element accepted while a result is pending");

   // The element count never passes capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= MAX_COUNT)
      else $error("element count beyond capacity");

   // After the final result of a run the block is back to an empty run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && count_ff == '0 && !dropped_ff))
      else $error("run state not cleared after the final result");

   // A result index never passes the final index of the run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_index_ff <= last_idx_ff))
      else $error("result index beyond the run");
`endif

endmodule

// ----- tb/sv/product_except_self_tb.sv -----
module product_except_self_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pes_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLD_LEN       = 500;
   localparam int DRAIN_CYCLES   = 50;
   localparam int ITEMS_PER_PHASE = 120;

   // One vector element as offered on the request stream.
   typedef struct {
      logic [DATA_W-1:0] value;
      logic              last;
   } vec_elem_type;

   // One product-except-self result as returned on the response stream.
   typedef struct {
      logic [INDEX_W-1:0] index;
      logic [DATA_W-1:0]  product;
      logic               run_end;
      logic               truncated;
   } except_prod_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [DATA_W-1:0]     req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   vec_elem_type    elem_queue[$];
   except_prod_type product_queue[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int items_added = 0;

   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int   hold_cnt = 0;

   // Shadow copy of the block's run state.
   logic [DATA_W-1:0] elem_mem[STORE_DEPTH];
   logic [DATA_W-1:0] pref_mem[STORE_DEPTH];
   int                held_count = 0;
   logic [DATA_W-1:0] run_prefix = 1;
   logic              dropped = 1'b0;

   product_except_self dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Fold one accepted element into the shadow state; on the final element, compute
   // every product except self and queue them in ascending index order.
   task automatic track_element(input logic [DATA_W-1:0] value, input logic last);
      except_prod_type   outs[STORE_DEPTH];
      logic [DATA_W-1:0] suffix;
      int                k;
      if (held_count < MAX_LEN) begin
         elem_mem[held_count] = value;
         pref_mem[held_count] = run_prefix;
         run_prefix = run_prefix * value;
         held_count++;
      end else begin
         dropped = 1'b1;
      end
      if (last) begin
         suffix = 1;
         for (k = held_count - 1; k >= 0; k--) begin
            outs[k].index = INDEX_W'(k);
            outs[k].product = pref_mem[k] * suffix;
            outs[k].run_end = (k == held_count - 1);
            outs[k].truncated = dropped;
            suffix = suffix * elem_mem[k];
         end
         for (k = 0; k < held_count; k++) begin
            product_queue = {product_queue, outs[k]};
         end
         held_count = 0;
         run_prefix = 1;
         dropped = 1'b0;
      end
   endtask

   task automatic push_elem(input logic [DATA_W-1:0] value, input logic last);
      vec_elem_type e;
      e.value = value;
      e.last = last;
      elem_queue = {elem_queue, e};
   endtask

   // Random element: full-range values half of the time, otherwise small values,
   // extremes, powers of two or an occasional zero.
   function automatic logic [DATA_W-1:0] random_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         return $urandom;
      end else if (pick < 80) begin
         return DATA_W'($signed($urandom_range(6)) - 3);
      end else if (pick < 88) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
         endcase
      end else if (pick < 97) begin
         return DATA_W'(1) << $urandom_range(31);
      end else begin
         return '0;
      end
   endfunction

   task automatic add_run(input int len);
      int i;
      for (i = 0; i < len; i++) begin
         push_elem(random_value(), i == len - 1);
      end
      items_added += len;
   endtask

   // Request driver: a new element is offered once the previous one has transferred.
   always @(posedge clock) begin : req_driver
      vec_elem_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_element(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (elem_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = elem_queue.pop_front();
               req_tdata <= nxt.value;
               req_tlast <= nxt.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response ready: one long hold-off on request, random stalls otherwise.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_cnt <= hold_cnt + 1;
         if (hold_cnt == HOLD_LEN - 1) begin
            hold_done <= 1'b1;
         end
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_val,
                                       input logic [DATA_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         fail_count++;
      end
   endfunction

   // Response monitor: each result transfer is checked against the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      except_prod_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (product_queue.size() == 0) begin
            $error("unexpected result: index %0d, product 0x%0h", rsp_tdata[INDEX_W-1:0],
                   rsp_tdata[INDEX_W+DATA_W-1:INDEX_W]);
            fail_count++;
         end else begin
            want = product_queue.pop_front();
            check_field("index", DATA_W'(want.index), DATA_W'(rsp_tdata[INDEX_W-1:0]));
            check_field("product", want.product, rsp_tdata[INDEX_W+DATA_W-1:INDEX_W]);
            check_field("run_end", DATA_W'(want.run_end), DATA_W'(rsp_tlast));
            check_field("truncated", DATA_W'(want.truncated), DATA_W'(rsp_tuser[0]));
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("product_except_self_tb NOT OK");
      $finish;
   end

   initial begin : main_seq
      int phase;
      int r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 87;
            end
            default: begin
               send_idle_pct = 36;
               recv_stall_pct = 36;
            end
         endcase

         if (phase == 0) begin
            // One-element vectors give 1 regardless of the value.
            push_elem(32'h8000_0000, 1'b1);
            push_elem(32'h7FFF_FFFF, 1'b1);
            // Both extremes together.
            push_elem(32'h7FFF_FFFF, 1'b0);
            push_elem(32'h8000_0000, 1'b1);
            // A single zero, then two zeros.
            push_elem(32'd3, 1'b0);
            push_elem(32'd0, 1'b0);
            push_elem(32'd7, 1'b1);
            push_elem(32'd0, 1'b0);
            push_elem(32'd5, 1'b0);
            push_elem(32'd0, 1'b1);
            // Products that wrap past 32 bits.
            push_elem(32'h7FFF_FFFF, 1'b0);
            push_elem(32'h7FFF_FFFF, 1'b0);
            push_elem(32'hFFFF_FFFF, 1'b0);
            push_elem(32'd2, 1'b1);
            push_elem(32'd2, 1'b0);
            push_elem(32'h4000_0000, 1'b0);
            push_elem(32'd3, 1'b1);
            // All negative ones.
            push_elem(32'hFFFF_FFFF, 1'b0);
            push_elem(32'hFFFF_FFFF, 1'b0);
            push_elem(32'hFFFF_FFFF, 1'b1);
            // A run that fills the stores exactly, then one whose final element is dropped.
            add_run(MAX_LEN);
            add_run(MAX_LEN + 1);
            // Stall the response side long enough for the block to back up its input.
            hold_go <= 1'b1;
         end

         // Mostly short vectors, some medium or long, a few at or past capacity.
         while (items_added < ITEMS_PER_PHASE * (phase + 1)) begin
            r = $urandom_range(99);
            if (r < 70) begin
               add_run($urandom_range(6, 1));
            end else if (r < 92) begin
               add_run($urandom_range(24, 7));
            end else if (r < 97) begin
               add_run($urandom_range(63, 25));
            end else begin
               add_run($urandom_range(MAX_LEN + 6, MAX_LEN));
            end
         end

         while (elem_queue.size() != 0 || req_tvalid) @(negedge clock);
      end

      while (product_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (product_queue.size() != 0) begin
         $error("%0d expected results never arrived", product_queue.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("product_except_self_tb OK");
      end else begin
         $display("product_except_self_tb NOT OK");
      end
      $finish;
   end

endmodule
